/* rtl/occupancy_grid_inflation_core_assert.svh */
// assertion macros shared by the occupancy grid rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef OCCUPANCY_GRID_INFLATION_CORE_ASSERT_SVH
`define OCCUPANCY_GRID_INFLATION_CORE_ASSERT_SVH

// clocked property, off while reset is active
`define OGI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define OGI_ASSERT_IMPL(lbl, ante, cons, msg) \
  `OGI_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/ogi_pkg.sv */
// shared constants, cell and command codes, port structs for the occupancy grid
// no dependencies
package ogi_pkg;

  // grid geometry
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_RADIUS  = 15;
  localparam int STORE_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_CELLS);

  // field widths
  localparam int X_W    = 6;
  localparam int Y_W    = 6;
  localparam int CFG_W  = 7;
  localparam int R_W    = 4;
  localparam int CELL_W = 2;
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 2;

  // horizontal distance words, saturating at one past the largest radius
  localparam int HD_W = $clog2(MAX_RADIUS + 2);
  localparam logic [HD_W-1:0] HD_NONE = HD_W'(MAX_RADIUS + 1);
  localparam int K_W  = $clog2(2 * MAX_RADIUS + 1);

  // cell codes
  localparam logic [CELL_W-1:0] CODE_FREE     = 2'd0;
  localparam logic [CELL_W-1:0] CODE_UNKNOWN  = 2'd1;
  localparam logic [CELL_W-1:0] CODE_OCCUPIED = 2'd2;
  localparam logic [CELL_W-1:0] CODE_INFLATED = 2'd3;

  // command codes
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INFLATE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;

  // cell store port request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } cell_req_t;

  // sweep status
  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

  // linear address of cell (x,y)
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y);
    cell_addr = ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
  endfunction

endpackage

/* rtl/ogi_ram.sv */
// simple dual port ram, one write and one registered read port
// no dependencies
module ogi_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ogi_sweep.sv */
// inflation sequencer: row distance passes into a distance ram, then a column pass
// depends on ogi_pkg, ogi_ram and the assertion macro header
`include "occupancy_grid_inflation_core_assert.svh"

module ogi_sweep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [ogi_pkg::CFG_W-1:0]  width_i,
  input  logic [ogi_pkg::CFG_W-1:0]  height_i,
  input  logic [ogi_pkg::R_W-1:0]    radius_i,
  input  logic [ogi_pkg::CELL_W-1:0] cell_rdata_i,
  output ogi_pkg::cell_req_t         cell_req_o,
  output ogi_pkg::sweep_stat_t       stat_o
);

  localparam int NY_W = ogi_pkg::Y_W + 2;
  localparam int SQ_W = 2 * ogi_pkg::HD_W + 1;

  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_FWD        = 7'b0000010,
    ST_FWD_DRAIN  = 7'b0000100,
    ST_BWD        = 7'b0001000,
    ST_BWD_DRAIN  = 7'b0010000,
    ST_VERT       = 7'b0100000,
    ST_VERT_DRAIN = 7'b1000000
  } sweep_state_e;

  sweep_state_e state_q, state_d;

  logic [ogi_pkg::X_W-1:0] cx_q, cx_d;
  logic [ogi_pkg::Y_W-1:0] cy_q, cy_d;
  logic [ogi_pkg::K_W-1:0] k_q, k_d;

  logic [ogi_pkg::X_W-1:0] w_last;
  logic [ogi_pkg::Y_W-1:0] h_last;
  logic [ogi_pkg::K_W-1:0] k_last;

  // issue stage
  logic                       issue;
  logic                       iss_first, iss_last;
  logic [ogi_pkg::ADDR_W-1:0] iss_addr;
  logic [NY_W-1:0]            ny;
  logic                       ny_ok;
  logic [ogi_pkg::R_W-1:0]    dy_abs;
  logic [2*ogi_pkg::R_W-1:0]  dy2;
  logic                       cell_re, hd_re;
  logic [ogi_pkg::ADDR_W-1:0] hd_raddr;

  // data stage
  logic                       p_valid_q;
  logic                       p_first_q, p_last_q, p_nok_q;
  logic [ogi_pkg::ADDR_W-1:0] p_addr_q;
  logic [2*ogi_pkg::R_W-1:0]  p_dy2_q;
  logic [2*ogi_pkg::R_W-1:0]  r2_q;

  logic [ogi_pkg::HD_W-1:0]   dist_q, dist_d;
  logic                       hit_q, hit_d;
  logic                       free_q, free_d;

  logic [ogi_pkg::HD_W-1:0]   hd_rdata;
  logic                       hd_we;
  logic [ogi_pkg::HD_W-1:0]   hd_wdata;

  logic                       fwd_ph, bwd_ph, vert_ph;
  logic                       src;
  logic [ogi_pkg::HD_W-1:0]   dist_inc, run;
  logic [2*ogi_pkg::HD_W-1:0] hd_sq;
  logic                       hit_now, hit_all, free_now;
  logic                       cell_we;

  // last indexes of the current pass
  assign w_last = ogi_pkg::X_W'(width_i - ogi_pkg::CFG_W'(1));
  assign h_last = ogi_pkg::Y_W'(height_i - ogi_pkg::CFG_W'(1));
  assign k_last = ogi_pkg::K_W'(radius_i) + ogi_pkg::K_W'(radius_i);

  // row of the column tap and its vertical offset
  assign ny     = NY_W'(cy_q) + NY_W'(k_q) - NY_W'(radius_i);
  assign ny_ok  = !ny[NY_W-1] && (ny < NY_W'(height_i));
  assign dy_abs = (k_q >= ogi_pkg::K_W'(radius_i)) ?
                  ogi_pkg::R_W'(k_q - ogi_pkg::K_W'(radius_i)) :
                  ogi_pkg::R_W'(ogi_pkg::K_W'(radius_i) - k_q);
  assign dy2    = (2*ogi_pkg::R_W)'(dy_abs) * (2*ogi_pkg::R_W)'(dy_abs);

  assign iss_addr = ogi_pkg::cell_addr(cx_q, cy_q);
  assign hd_raddr = (state_q == ST_VERT) ? ogi_pkg::cell_addr(cx_q, ny[ogi_pkg::Y_W-1:0])
                                         : iss_addr;

  // sequencer and address generation
  always_comb begin
    state_d   = state_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    k_d       = k_q;
    issue     = 1'b0;
    iss_first = 1'b0;
    iss_last  = 1'b0;
    cell_re   = 1'b0;
    hd_re     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          state_d = ST_FWD;
          cx_d    = '0;
          cy_d    = '0;
        end
      end
      ST_FWD: begin
        issue     = 1'b1;
        cell_re   = 1'b1;
        iss_first = (cx_q == '0);
        if (cx_q == w_last) begin
          cx_d = '0;
          cy_d = cy_q + ogi_pkg::Y_W'(1);
          if (cy_q == h_last) begin
            state_d = ST_FWD_DRAIN;
          end
        end else begin
          cx_d = cx_q + ogi_pkg::X_W'(1);
        end
      end
      ST_FWD_DRAIN: begin
        state_d = ST_BWD;
        cx_d    = w_last;
        cy_d    = '0;
      end
      ST_BWD: begin
        issue     = 1'b1;
        cell_re   = 1'b1;
        hd_re     = 1'b1;
        iss_first = (cx_q == w_last);
        if (cx_q == '0) begin
          cx_d = w_last;
          cy_d = cy_q + ogi_pkg::Y_W'(1);
          if (cy_q == h_last) begin
            state_d = ST_BWD_DRAIN;
          end
        end else begin
          cx_d = cx_q - ogi_pkg::X_W'(1);
        end
      end
      ST_BWD_DRAIN: begin
        state_d = ST_VERT;
        cx_d    = '0;
        cy_d    = '0;
        k_d     = '0;
      end
      ST_VERT: begin
        issue     = 1'b1;
        cell_re   = (k_q == '0);
        hd_re     = ny_ok;
        iss_first = (k_q == '0);
        iss_last  = (k_q == k_last);
        if (k_q == k_last) begin
          k_d = '0;
          if (cx_q == w_last) begin
            cx_d = '0;
            cy_d = cy_q + ogi_pkg::Y_W'(1);
            if (cy_q == h_last) begin
              state_d = ST_VERT_DRAIN;
            end
          end else begin
            cx_d = cx_q + ogi_pkg::X_W'(1);
          end
        end else begin
          k_d = k_q + ogi_pkg::K_W'(1);
        end
      end
      ST_VERT_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // phase of the word in the data stage
  assign fwd_ph  = (state_q == ST_FWD) || (state_q == ST_FWD_DRAIN);
  assign bwd_ph  = (state_q == ST_BWD) || (state_q == ST_BWD_DRAIN);
  assign vert_ph = (state_q == ST_VERT) || (state_q == ST_VERT_DRAIN);

  // running distance to the nearest source along the row
  assign src      = (cell_rdata_i == ogi_pkg::CODE_OCCUPIED) ||
                    (cell_rdata_i == ogi_pkg::CODE_UNKNOWN);
  assign dist_inc = (dist_q >= ogi_pkg::HD_NONE) ? ogi_pkg::HD_NONE
                                                 : dist_q + ogi_pkg::HD_W'(1);
  assign run      = src ? '0 : (p_first_q ? ogi_pkg::HD_NONE : dist_inc);

  // circle test against the row distance found in the tapped row
  assign hd_sq    = (2*ogi_pkg::HD_W)'(hd_rdata) * (2*ogi_pkg::HD_W)'(hd_rdata);
  assign hit_now  = p_nok_q && (hd_rdata <= ogi_pkg::HD_W'(radius_i)) &&
                    ((SQ_W'(hd_sq) + SQ_W'(p_dy2_q)) <= SQ_W'(r2_q));
  assign hit_all  = hit_now || (!p_first_q && hit_q);
  assign free_now = p_first_q ? (cell_rdata_i == ogi_pkg::CODE_FREE) : free_q;

  always_comb begin
    dist_d   = dist_q;
    hit_d    = hit_q;
    free_d   = free_q;
    hd_we    = 1'b0;
    hd_wdata = run;
    cell_we  = 1'b0;
    if (p_valid_q && (fwd_ph || bwd_ph)) begin
      hd_we    = 1'b1;
      dist_d   = run;
      hd_wdata = (bwd_ph && (hd_rdata < run)) ? hd_rdata : run;
    end
    if (p_valid_q && vert_ph) begin
      hit_d   = hit_all;
      free_d  = free_now;
      cell_we = p_last_q && hit_all && free_now;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cx_q      <= '0;
      cy_q      <= '0;
      k_q       <= '0;
      p_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      k_q       <= k_d;
      p_valid_q <= issue;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    p_first_q <= iss_first;
    p_last_q  <= iss_last;
    p_nok_q   <= ny_ok;
    p_addr_q  <= iss_addr;
    p_dy2_q   <= dy2;
    dist_q    <= dist_d;
    hit_q     <= hit_d;
    free_q    <= free_d;
    if (go_i) begin
      r2_q <= (2*ogi_pkg::R_W)'(radius_i) * (2*ogi_pkg::R_W)'(radius_i);
    end
  end

  // row distance store
  ogi_ram #(
    .DEPTH(ogi_pkg::STORE_CELLS),
    .WIDTH(ogi_pkg::HD_W)
  ) u_hd_ram (
    .clk_i   (clk_i),
    .we_i    (hd_we),
    .waddr_i (p_addr_q),
    .wdata_i (hd_wdata),
    .re_i    (hd_re),
    .raddr_i (hd_raddr),
    .rdata_o (hd_rdata)
  );

  assign cell_req_o.we    = cell_we;
  assign cell_req_o.waddr = p_addr_q;
  assign cell_req_o.wdata = ogi_pkg::CODE_INFLATED;
  assign cell_req_o.re    = cell_re;
  assign cell_req_o.raddr = iss_addr;

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_VERT_DRAIN);

  // checks
  `OGI_ASSERT_IMPL(a_go_idle, go_i, state_q == ST_IDLE, "start of a pass while sweeping")
  `OGI_ASSERT_IMPL(a_hd_no_overlap, hd_we && hd_re, p_addr_q != hd_raddr,
                   "distance ram read and write hit the same entry")
  `OGI_ASSERT_IMPL(a_cell_no_overlap, cell_we && cell_re, p_addr_q != iss_addr,
                   "cell store read and write hit the same entry")

endmodule

/* rtl/occupancy_grid_inflation_core.sv */
// top level of the occupancy grid store: command decode, config registers, cell store
// depends on ogi_pkg, ogi_ram, ogi_sweep and the assertion macro header
//
// Usage:
//   A command word (action_i, x_pos_i, y_pos_i, cell_in_i) is taken at a rising edge
//   with start high and busy low. Each command gives one result word, shown for one
//   cycle with result_valid_o high; the receiver cannot hold it off.
//   Write and read give their result in the cycle after the command, and busy
//   stays low, so a new command may follow every cycle.
//   Inflate raises busy and runs three passes over the w*h cells in use: a forward
//   and a backward row pass that fill the row distance ram, then a column pass that
//   reads it back for every row within the radius; the result follows the last drain
//   state. With a zero width, height or radius it answers in the next cycle like
//   a read.
//   Configuration words (cfg_index_i, cfg_data_i) are taken whenever cfg_valid_i is
//   high; cfg_ready_o is always high. Write them only while no command is in work.
//   After reset the cell store is swept to unknown, one cell a cycle, over all 4096
//   cells with busy high; configuration writes are taken during the sweep.
`include "occupancy_grid_inflation_core_assert.svh"

module occupancy_grid_inflation_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic [ogi_pkg::ACT_W-1:0]  action_i,
  input  logic [ogi_pkg::X_W-1:0]    x_pos_i,
  input  logic [ogi_pkg::Y_W-1:0]    y_pos_i,
  input  logic [ogi_pkg::CELL_W-1:0] cell_in_i,
  // result channel
  output logic                       result_valid_o,
  output logic [ogi_pkg::CELL_W-1:0] cell_out_o,
  output logic                       accepted_o,
  // configuration channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ogi_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [ogi_pkg::CFG_W-1:0]  cfg_data_i
);

  logic [ogi_pkg::CFG_W-1:0]  width_q, height_q;
  logic [ogi_pkg::R_W-1:0]    radius_q;
  logic [ogi_pkg::CFG_W-1:0]  w_used, h_used;
  logic [ogi_pkg::R_W-1:0]    r_used;

  logic                       clr_busy_q;
  logic [ogi_pkg::ADDR_W-1:0] clr_addr_q;

  logic                       cmd_acc, in_bounds, go;
  logic [ogi_pkg::ADDR_W-1:0] cmd_addr;

  logic                       res_valid_q, res_valid_d;
  logic                       res_ram_q, res_ram_d;
  logic [ogi_pkg::CELL_W-1:0] res_cell_q, res_cell_d;
  logic                       res_acc_q, res_acc_d;

  ogi_pkg::cell_req_t         sweep_req, cell_req;
  ogi_pkg::sweep_stat_t       sweep_stat;
  logic [ogi_pkg::CELL_W-1:0] cell_rdata;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ogi_pkg::CFG_W'(ogi_pkg::MAX_WIDTH);
      height_q <= ogi_pkg::CFG_W'(ogi_pkg::MAX_HEIGHT);
      radius_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ogi_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        ogi_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        ogi_pkg::REG_RADIUS: radius_q <= cfg_data_i[ogi_pkg::R_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid size and radius
  assign w_used = (width_q > ogi_pkg::CFG_W'(ogi_pkg::MAX_WIDTH)) ?
                  ogi_pkg::CFG_W'(ogi_pkg::MAX_WIDTH) : width_q;
  assign h_used = (height_q > ogi_pkg::CFG_W'(ogi_pkg::MAX_HEIGHT)) ?
                  ogi_pkg::CFG_W'(ogi_pkg::MAX_HEIGHT) : height_q;
  assign r_used = (radius_q > ogi_pkg::R_W'(ogi_pkg::MAX_RADIUS)) ?
                  ogi_pkg::R_W'(ogi_pkg::MAX_RADIUS) : radius_q;

  // command decode
  assign busy      = clr_busy_q || sweep_stat.busy;
  assign cmd_acc   = start && !busy;
  assign in_bounds = (ogi_pkg::CFG_W'(x_pos_i) < w_used) &&
                     (ogi_pkg::CFG_W'(y_pos_i) < h_used);
  assign cmd_addr  = ogi_pkg::cell_addr(x_pos_i, y_pos_i);
  assign go        = cmd_acc && (action_i == ogi_pkg::ACT_INFLATE) &&
                     (w_used != '0) && (h_used != '0) && (r_used != '0);

  // result word
  always_comb begin
    res_valid_d = (cmd_acc && !go) || sweep_stat.done;
    res_ram_d   = res_ram_q;
    res_cell_d  = res_cell_q;
    res_acc_d   = res_acc_q;
    if (sweep_stat.done) begin
      res_ram_d  = 1'b0;
      res_cell_d = ogi_pkg::CODE_FREE;
      res_acc_d  = 1'b1;
    end else if (cmd_acc) begin
      res_ram_d  = 1'b0;
      res_cell_d = ogi_pkg::CODE_FREE;
      res_acc_d  = 1'b0;
      unique case (action_i)
        ogi_pkg::ACT_WRITE: res_acc_d = in_bounds;
        ogi_pkg::ACT_READ: begin
          res_ram_d  = in_bounds;
          res_cell_d = ogi_pkg::CODE_OCCUPIED;
        end
        ogi_pkg::ACT_INFLATE: res_acc_d = 1'b1;
        ogi_pkg::ACT_NONE:    res_acc_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_ram_q   <= 1'b0;
      res_cell_q  <= ogi_pkg::CODE_FREE;
      res_acc_q   <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      res_ram_q   <= res_ram_d;
      res_cell_q  <= res_cell_d;
      res_acc_q   <= res_acc_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign cell_out_o     = res_ram_q ? cell_rdata : res_cell_q;
  assign accepted_o     = res_acc_q;

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + ogi_pkg::ADDR_W'(1);
      if (clr_addr_q == ogi_pkg::ADDR_W'(ogi_pkg::STORE_CELLS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // cell store port arbitration
  always_comb begin
    priority if (clr_busy_q) begin
      cell_req.we    = 1'b1;
      cell_req.waddr = clr_addr_q;
      cell_req.wdata = ogi_pkg::CODE_UNKNOWN;
      cell_req.re    = 1'b0;
      cell_req.raddr = clr_addr_q;
    end else if (sweep_stat.busy) begin
      cell_req = sweep_req;
    end else begin
      cell_req.we    = cmd_acc && (action_i == ogi_pkg::ACT_WRITE) && in_bounds;
      cell_req.waddr = cmd_addr;
      cell_req.wdata = cell_in_i;
      cell_req.re    = cmd_acc && (action_i == ogi_pkg::ACT_READ) && in_bounds;
      cell_req.raddr = cmd_addr;
    end
  end

  ogi_ram #(
    .DEPTH(ogi_pkg::STORE_CELLS),
    .WIDTH(ogi_pkg::CELL_W)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_req.we),
    .waddr_i (cell_req.waddr),
    .wdata_i (cell_req.wdata),
    .re_i    (cell_req.re),
    .raddr_i (cell_req.raddr),
    .rdata_o (cell_rdata)
  );

  // inflation sequencer
  ogi_sweep u_sweep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (go),
    .width_i      (w_used),
    .height_i     (h_used),
    .radius_i     (r_used),
    .cell_rdata_i (cell_rdata),
    .cell_req_o   (sweep_req),
    .stat_o       (sweep_stat)
  );

  // checks
  `OGI_ASSERT_IMPL(a_res_origin, result_valid_o, $past(cmd_acc) || $past(sweep_stat.done),
                   "result word without a command or finished pass")
  `OGI_ASSERT(a_done_result, sweep_stat.done |=> (result_valid_o && accepted_o),
              "finished pass did not report accepted")
  `OGI_ASSERT_IMPL(a_sweep_not_clearing, sweep_stat.busy, !clr_busy_q,
                   "inflation pass during the clearing pass")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

// self-checking bench for occupancy_grid_inflation_core: a directed plan, then random phases
// keeps its own grid copy and register copies to predict every result word
// depends on ogi_pkg and the rtl of the core

module testbench;
  import ogi_pkg::*;

  localparam int     CLK_HALF        = 5;
  localparam int     RESET_CYCLES    = 10;
  localparam int     SETTLE_CYCLES   = 4;
  localparam int     DRAIN_CYCLES    = 8;
  localparam int     RANDOM_PHASES   = 10;
  localparam int     WORDS_PER_PHASE = 70;
  localparam int     INFLATE_BUDGET  = 6000;
  localparam longint CYCLE_LIMIT     = 20_000_000;

  // one result word as the core shows it
  typedef struct packed {
    logic [CELL_W-1:0] cell_code;
    logic              acc;
  } grid_result_t;

  // one row of the directed plan: a command word or a register write
  typedef struct packed {
    logic              is_reg;
    logic [ACT_W-1:0]  act;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [CELL_W-1:0] code;
    logic [IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]  reg_data;
    logic              known;
    grid_result_t      known_res;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [ACT_W-1:0]  action_i;
  logic [X_W-1:0]    x_pos_i;
  logic [Y_W-1:0]    y_pos_i;
  logic [CELL_W-1:0] cell_in_i;
  logic              result_valid_o;
  logic [CELL_W-1:0] cell_out_o;
  logic              accepted_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i;
  logic [CFG_W-1:0]  cfg_data_i;

  // grid copy, pre-pass snapshot and register copies
  logic [CELL_W-1:0] grid_copy [STORE_CELLS];
  logic [CELL_W-1:0] pre_pass  [STORE_CELLS];
  logic [CFG_W-1:0]  width_reg;
  logic [CFG_W-1:0]  height_reg;
  logic [R_W-1:0]    radius_reg;

  grid_result_t expected_words [$];
  plan_row_t    directed_plan  [$];
  int           fail_count  = 0;
  longint       cycle_count = 0;

  occupancy_grid_inflation_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .cell_in_i      (cell_in_i),
    .result_valid_o (result_valid_o),
    .cell_out_o     (cell_out_o),
    .accepted_o     (accepted_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // effective geometry, oversized registers saturate
  function automatic int used_width();
    return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int used_height();
    return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
  endfunction

  function automatic int used_radius();
    return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
  endfunction

  function automatic bit in_grid(int x, int y);
    return (x < used_width()) && (y < used_height());
  endfunction

  // cycles an inflate takes under the current registers
  function automatic int inflate_cycles();
    if (used_width() == 0 || used_height() == 0 || used_radius() == 0)
      return 1;
    return used_width() * used_height() * (2 * used_radius() + 3) + 4;
  endfunction

  // coordinate, mostly inside the grid in use
  function automatic logic [X_W-1:0] pick_coord(int limit);
    if (limit > 0 && $urandom_range(0, 99) < 85)
      return X_W'($urandom_range(0, limit - 1));
    return X_W'($urandom_range(0, 63));
  endfunction

  // circular dilation, sources taken from the contents before the pass
  task automatic inflate_copy();
    int w, h, r, x, y, dx, dy, nx, ny;
    logic [CELL_W-1:0] src;
    w = used_width();
    h = used_height();
    r = used_radius();
    if (r == 0)
      return;
    for (int i = 0; i < STORE_CELLS; i++)
      pre_pass[i] = grid_copy[i];
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        src = pre_pass[y * MAX_WIDTH + x];
        if (src == CODE_OCCUPIED || src == CODE_UNKNOWN) begin
          for (dy = -r; dy <= r; dy++) begin
            for (dx = -r; dx <= r; dx++) begin
              nx = x + dx;
              ny = y + dy;
              if (nx >= 0 && ny >= 0 && nx < w && ny < h && dx * dx + dy * dy <= r * r &&
                  grid_copy[ny * MAX_WIDTH + nx] == CODE_FREE)
                grid_copy[ny * MAX_WIDTH + nx] = CODE_INFLATED;
            end
          end
        end
      end
    end
  endtask

  // next result word of a command, updating the grid copy
  task automatic predict_word(input logic [ACT_W-1:0] act, input logic [X_W-1:0] x,
                              input logic [Y_W-1:0] y, input logic [CELL_W-1:0] code,
                              output grid_result_t res);
    res = '0;
    case (act)
      ACT_WRITE: begin
        if (in_grid(int'(x), int'(y))) begin
          grid_copy[int'(y) * MAX_WIDTH + int'(x)] = code;
          res.acc = 1'b1;
        end
      end
      ACT_READ: begin
        res.cell_code = in_grid(int'(x), int'(y)) ? grid_copy[int'(y) * MAX_WIDTH + int'(x)]
                                                  : CODE_OCCUPIED;
      end
      ACT_INFLATE: begin
        inflate_copy();
        res.acc = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic void plan_word(logic [ACT_W-1:0] act, logic [X_W-1:0] x,
                                    logic [Y_W-1:0] y, logic [CELL_W-1:0] code,
                                    logic known, logic [CELL_W-1:0] k_cell, logic k_acc);
    plan_row_t row;
    row = '0;
    row.act = act;
    row.x = x;
    row.y = y;
    row.code = code;
    row.known = known;
    row.known_res.cell_code = k_cell;
    row.known_res.acc = k_acc;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    directed_plan.push_back(row);
  endfunction

  // present a command word and hold it until taken
  task automatic issue_word(input logic [ACT_W-1:0] act, input logic [X_W-1:0] x,
                            input logic [Y_W-1:0] y, input logic [CELL_W-1:0] code,
                            input logic known, input grid_result_t known_res);
    grid_result_t res;
    start     <= 1'b1;
    action_i  <= act;
    x_pos_i   <= x;
    y_pos_i   <= y;
    cell_in_i <= code;
    do @(posedge clk_i); while (busy);
    predict_word(act, x, y, code, res);
    expected_words.push_back(known ? known_res : res);
  endtask

  // random gap between command words
  task automatic maybe_idle(input logic quiet);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // stop issuing and wait until every result word is back
  task automatic settle();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WIDTH:  width_reg = data;
      REG_HEIGHT: height_reg = data;
      REG_RADIUS: radius_reg = data[R_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    grid_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got cell_out %0d accepted %0d",
                 $time, cell_out_o, accepted_o);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (cell_out_o !== want.cell_code) begin
          $display("%0t: cell_out mismatch, expected %0d, got %0d", $time, want.cell_code,
                   cell_out_o);
          fail_count++;
        end
        if (accepted_o !== want.acc) begin
          $display("%0t: accepted mismatch, expected %0d, got %0d", $time, want.acc,
                   accepted_o);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded the cycle limit", $time);
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int counted, pick, rw, rh, rr;
    logic quiet;
    logic [ACT_W-1:0] act;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [CELL_W-1:0] code;

    rst_ni      <= 1'b0;
    start       <= 1'b0;
    action_i    <= ACT_WRITE;
    x_pos_i     <= '0;
    y_pos_i     <= '0;
    cell_in_i   <= CODE_FREE;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_WIDTH;
    cfg_data_i  <= '0;

    for (int i = 0; i < STORE_CELLS; i++)
      grid_copy[i] = CODE_UNKNOWN;
    width_reg  = 7'd64;
    height_reg = 7'd64;
    radius_reg = '0;

    // grid after reset, corners, all codes and actions
    plan_word(ACT_READ, 6'd0, 6'd0, CODE_FREE, 1'b1, CODE_UNKNOWN, 1'b0);
    plan_word(ACT_READ, 6'd63, 6'd63, CODE_INFLATED, 1'b1, CODE_UNKNOWN, 1'b0);
    plan_word(ACT_WRITE, 6'd63, 6'd63, CODE_OCCUPIED, 1'b1, CODE_FREE, 1'b1);
    plan_word(ACT_WRITE, 6'd0, 6'd0, CODE_FREE, 1'b1, CODE_FREE, 1'b1);
    plan_word(ACT_WRITE, 6'd1, 6'd0, CODE_FREE, 1'b1, CODE_FREE, 1'b1);
    plan_word(ACT_WRITE, 6'd0, 6'd1, CODE_INFLATED, 1'b1, CODE_FREE, 1'b1);
    plan_word(ACT_READ, 6'd63, 6'd63, CODE_FREE, 1'b1, CODE_OCCUPIED, 1'b0);
    plan_word(ACT_NONE, 6'd21, 6'd42, CODE_INFLATED, 1'b1, CODE_FREE, 1'b0);
    // zero radius: inflate is taken but leaves free cells alone
    plan_word(ACT_INFLATE, 6'd63, 6'd0, CODE_OCCUPIED, 1'b1, CODE_FREE, 1'b1);
    plan_word(ACT_READ, 6'd0, 6'd0, CODE_UNKNOWN, 1'b1, CODE_FREE, 1'b0);
    // oversized width, zero height: nothing is inside
    plan_reg(REG_WIDTH, 7'd127);
    plan_reg(REG_HEIGHT, 7'd0);
    plan_reg(REG_RADIUS, 7'd3);
    plan_word(ACT_READ, 6'd0, 6'd0, CODE_FREE, 1'b1, CODE_OCCUPIED, 1'b0);
    plan_word(ACT_WRITE, 6'd5, 6'd5, CODE_FREE, 1'b1, CODE_FREE, 1'b0);
    plan_word(ACT_INFLATE, 6'd0, 6'd0, CODE_FREE, 1'b1, CODE_FREE, 1'b1);
    // single column
    plan_reg(REG_HEIGHT, 7'd64);
    plan_reg(REG_WIDTH, 7'd1);
    plan_word(ACT_WRITE, 6'd1, 6'd0, CODE_OCCUPIED, 1'b1, CODE_FREE, 1'b0);
    plan_word(ACT_READ, 6'd1, 6'd0, CODE_FREE, 1'b1, CODE_OCCUPIED, 1'b0);
    // full grid again, contents kept at fixed addresses
    plan_reg(REG_WIDTH, 7'd64);
    plan_reg(REG_HEIGHT, 7'd127);
    plan_reg(REG_RADIUS, 7'd1);
    plan_word(ACT_READ, 6'd1, 6'd0, CODE_FREE, 1'b1, CODE_FREE, 1'b0);
    plan_word(ACT_INFLATE, 6'd0, 6'd63, CODE_FREE, 1'b0, CODE_FREE, 1'b0);
    plan_word(ACT_READ, 6'd1, 6'd0, CODE_FREE, 1'b0, CODE_FREE, 1'b0);
    // largest radius on a thin grid
    plan_reg(REG_WIDTH, 7'd20);
    plan_reg(REG_HEIGHT, 7'd3);
    plan_reg(REG_RADIUS, 7'd15);
    plan_word(ACT_WRITE, 6'd19, 6'd2, CODE_FREE, 1'b0, CODE_FREE, 1'b0);
    plan_word(ACT_WRITE, 6'd10, 6'd1, CODE_FREE, 1'b0, CODE_FREE, 1'b0);
    plan_word(ACT_INFLATE, 6'd0, 6'd0, CODE_FREE, 1'b0, CODE_FREE, 1'b0);
    plan_word(ACT_READ, 6'd10, 6'd1, CODE_FREE, 1'b0, CODE_FREE, 1'b0);
    plan_word(ACT_READ, 6'd19, 6'd2, CODE_FREE, 1'b0, CODE_FREE, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed plan
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_reg) begin
        settle();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_data);
      end else begin
        issue_word(directed_plan[i].act, directed_plan[i].x, directed_plan[i].y,
                   directed_plan[i].code, directed_plan[i].known, directed_plan[i].known_res);
        maybe_idle(1'b0);
      end
    end

    // random phases, each with its own geometry and radius
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet = (phase == 3 || phase == 4);
      case ($urandom_range(0, 9))
        0:       rw = 0;
        1:       rw = 127;
        2:       rw = 64;
        3:       rw = $urandom_range(65, 126);
        default: rw = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       rh = 0;
        1:       rh = 127;
        2:       rh = 64;
        3:       rh = $urandom_range(65, 126);
        default: rh = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 5))
        0:       rr = 0;
        1:       rr = 15;
        default: rr = $urandom_range(1, 15);
      endcase
      settle();
      write_reg(REG_WIDTH, rw[CFG_W-1:0]);
      write_reg(REG_HEIGHT, rh[CFG_W-1:0]);
      write_reg(REG_RADIUS, rr[CFG_W-1:0]);

      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        x = pick_coord(used_width());
        y = pick_coord(used_height());
        code = $urandom_range(0, 1) ? CODE_FREE : CELL_W'($urandom_range(0, 3));
        if (pick < 45)
          act = ACT_WRITE;
        else if (pick < 87)
          act = ACT_READ;
        else if (pick < 94)
          // large sweeps stay rare: fall back to a read when the pass is too long
          act = (inflate_cycles() <= INFLATE_BUDGET) ? ACT_INFLATE : ACT_READ;
        else
          act = ACT_NONE;
        issue_word(act, x, y, code, 1'b0, '0);
        if (act != ACT_NONE)
          counted++;
        maybe_idle(quiet);
      end
    end

    // drain and report
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ogi_pkg.sv
rtl/ogi_ram.sv
rtl/ogi_sweep.sv
rtl/occupancy_grid_inflation_core.sv
verif/testbench.sv
